### sv/fril_pkg.sv
// shared constants, codes and control types for the frame range lookup
package fril_pkg;

  localparam int MAX_RANGES = 16;
  localparam int CNT_W      = $clog2(MAX_RANGES + 1);
  localparam int IDX_W      = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;

  localparam int FRAME_W = 32;
  localparam int STEP_W  = 31;
  localparam int INDEX_W = 32;
  localparam int HELD_W  = 5;
  localparam int STAT_W  = 2;
  // running index grows by at most 2^32 per range in the gap-spanning walk
  localparam int TMP_W   = 38;
  localparam int ENTRY_W = 2 * FRAME_W + STEP_W;

  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_APPEND = 2'd1,
    ACT_QUERY  = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_RANGE  = 2'd2,
    ST_REJECT = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_RD,
    S_LAT,
    S_EVAL,
    S_DIV_CNT,
    S_LST,
    S_MUL,
    S_LADD,
    S_DIV_SNAP,
    S_RDN,
    S_LATN,
    S_GAP,
    S_DIV_END,
    S_IMPL_FIN,
    S_FINISH
  } state_t;

  typedef enum logic [2:0] {
    RES_OK,
    RES_EMPTY,
    RES_RANGE,
    RES_REJECT,
    RES_LISTED,
    RES_IMPLIED,
    RES_SNAP,
    RES_STEPEND
  } res_sel_t;

  typedef enum logic {
    DIV_DIFF,
    DIV_TMP
  } div_sel_t;

  typedef struct packed {
    logic     latch_in;
    logic     do_clear;
    logic     do_append;
    logic     ram_rd;
    logic     rd_next;
    logic     latch_cur;
    logic     latch_next;
    logic     r_inc;
    logic     lo_load;
    logic     div_start;
    div_sel_t div_sel;
    logic     cnt_load;
    logic     prod_load;
    logic     tmp_sub_cnt;
    logic     tmp_sub_gap;
    logic     res_load;
    res_sel_t res_sel;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    action_t act;
    logic    implied;
    logic    snap;
    logic    cnt_zero;
    logic    append_bad;
    logic    last;
    logic    tmp_lt_cnt;
    logic    tmp_lt_span;
    logic    gap_hit;
    logic    div_done;
    logic    out_free;
  } stat_t;

endpackage

### sv/fril_ram.sv
// generic single-write, single-read ram with registered read data
module fril_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                   clk,
  input  logic                   we,
  input  logic [AW-1:0]          waddr,
  input  logic [WIDTH-1:0]       wdata,
  input  logic                   re,
  input  logic [AW-1:0]          raddr,
  output logic [WIDTH-1:0]       rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

### sv/fril_div.sv
// iterative unsigned divider, one quotient bit per cycle
module fril_div
  import fril_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [INDEX_W-1:0] dividend,
  input  logic [STEP_W-1:0]  divisor,
  output logic [INDEX_W-1:0] quotient,
  output logic [STEP_W-1:0]  remainder,
  output logic               done
);
  localparam int BIT_W = $clog2(INDEX_W);

  logic               busy;
  logic [BIT_W-1:0]   bit_cnt;
  logic [INDEX_W-1:0] rem;
  logic [INDEX_W-1:0] quo;
  logic [STEP_W-1:0]  dvs;
  logic [INDEX_W-1:0] shifted;
  logic               fits;

  // one restoring step
  assign shifted = {rem[INDEX_W-2:0], quo[INDEX_W-1]};
  assign fits    = shifted >= INDEX_W'(dvs);

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      done    <= 1'b0;
      bit_cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy    <= 1'b1;
        bit_cnt <= '0;
      end else if (busy) begin
        bit_cnt <= bit_cnt + BIT_W'(1);
        if (bit_cnt == BIT_W'(INDEX_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= fits ? (shifted - INDEX_W'(dvs)) : shifted;
      quo <= {quo[INDEX_W-2:0], fits};
    end
  end

  assign quotient  = quo;
  assign remainder = rem[STEP_W-1:0];
endmodule

### sv/fril_ctrl.sv
// sequencer for append, clear and the range walk of a query
module fril_ctrl
  import fril_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t st,
  output cmd_t  cmd
);
  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_DECODE;
      end
      S_DECODE: begin
        if (st.act == ACT_QUERY && !st.cnt_zero) state_next = S_RD;
        else state_next = S_FINISH;
      end
      S_RD:  state_next = S_LAT;
      S_LAT: state_next = S_EVAL;
      S_EVAL: begin
        if (st.implied && !st.snap) begin
          state_next = st.last ? S_IMPL_FIN : S_RD;
        end else if (!st.implied) begin
          state_next = S_DIV_CNT;
        end else if (st.tmp_lt_span) begin
          state_next = S_DIV_SNAP;
        end else begin
          state_next = st.last ? S_FINISH : S_RDN;
        end
      end
      S_DIV_CNT: begin
        if (st.div_done) state_next = S_LST;
      end
      S_LST: begin
        if (st.tmp_lt_cnt) state_next = S_MUL;
        else state_next = st.last ? S_FINISH : S_RD;
      end
      S_MUL:  state_next = S_LADD;
      S_LADD: state_next = S_FINISH;
      S_DIV_SNAP: begin
        if (st.div_done) state_next = S_FINISH;
      end
      S_RDN:  state_next = S_LATN;
      S_LATN: state_next = S_GAP;
      S_GAP: begin
        state_next = st.gap_hit ? S_DIV_END : S_RD;
      end
      S_DIV_END: begin
        if (st.div_done) state_next = S_FINISH;
      end
      S_IMPL_FIN: state_next = S_FINISH;
      S_FINISH: begin
        if (st.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready     = 1'b1;
        cmd.latch_in = in_valid;
      end
      S_DECODE: begin
        case (st.act)
          ACT_CLEAR: begin
            cmd.do_clear = 1'b1;
            cmd.res_load = 1'b1;
            cmd.res_sel  = RES_OK;
          end
          ACT_APPEND: begin
            cmd.res_load  = 1'b1;
            cmd.do_append = !st.append_bad;
            cmd.res_sel   = st.append_bad ? RES_REJECT : RES_OK;
          end
          ACT_QUERY: begin
            cmd.res_load = st.cnt_zero;
            cmd.res_sel  = RES_EMPTY;
          end
          default: begin
            cmd.res_load = 1'b1;
            cmd.res_sel  = RES_OK;
          end
        endcase
      end
      S_RD:  cmd.ram_rd = 1'b1;
      S_LAT: cmd.latch_cur = 1'b1;
      S_EVAL: begin
        if (st.implied && !st.snap) begin
          cmd.lo_load = 1'b1;
          cmd.r_inc   = !st.last;
        end else if (!st.implied) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_DIFF;
        end else if (st.tmp_lt_span) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_TMP;
        end else if (st.last) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = RES_RANGE;
        end
      end
      S_DIV_CNT: cmd.cnt_load = st.div_done;
      S_LST: begin
        if (!st.tmp_lt_cnt) begin
          cmd.tmp_sub_cnt = 1'b1;
          cmd.r_inc       = !st.last;
          cmd.res_load    = st.last;
          cmd.res_sel     = RES_RANGE;
        end
      end
      S_MUL: cmd.prod_load = 1'b1;
      S_LADD: begin
        cmd.res_load = 1'b1;
        cmd.res_sel  = RES_LISTED;
      end
      S_DIV_SNAP: begin
        cmd.res_load = st.div_done;
        cmd.res_sel  = RES_SNAP;
      end
      S_RDN: begin
        cmd.ram_rd  = 1'b1;
        cmd.rd_next = 1'b1;
      end
      S_LATN: cmd.latch_next = 1'b1;
      S_GAP: begin
        if (st.gap_hit) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_DIFF;
        end else begin
          cmd.tmp_sub_gap = 1'b1;
          cmd.r_inc       = 1'b1;
        end
      end
      S_DIV_END: begin
        cmd.res_load = st.div_done;
        cmd.res_sel  = RES_STEPEND;
      end
      S_IMPL_FIN: begin
        cmd.res_load = 1'b1;
        cmd.res_sel  = RES_IMPLIED;
      end
      S_FINISH: cmd.out_load = st.out_free;
      default: ;
    endcase
  end
endmodule

### sv/fril_dp.sv
// range table, walk registers, divider, multiplier and output register
module fril_dp
  import fril_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  cmd_t                      cmd,
  output stat_t                     st,
  input  logic [1:0]                in_action,
  input  logic signed [FRAME_W-1:0] in_start,
  input  logic signed [FRAME_W-1:0] in_end,
  input  logic [STEP_W-1:0]         in_step,
  input  logic [INDEX_W-1:0]        in_index,
  input  logic                      in_implied,
  input  logic                      in_snap,
  input  logic                      out_ready,
  output logic                      out_valid,
  output logic signed [FRAME_W-1:0] out_frame,
  output logic [STAT_W-1:0]         out_status,
  output logic [HELD_W-1:0]         out_held
);
  // latched item
  action_t                   act;
  logic signed [FRAME_W-1:0] a_s, a_e;
  logic [STEP_W-1:0]         a_st;
  logic                      imp, snp;

  logic [CNT_W-1:0]          count;
  logic [CNT_W-1:0]          r;
  logic [CNT_W-1:0]          r_plus;
  logic [TMP_W-1:0]          tmp;
  logic signed [FRAME_W-1:0] cur_s, cur_e, lo, ns;
  logic [STEP_W-1:0]         cur_st;
  logic [INDEX_W:0]          cnt;
  logic [FRAME_W-1:0]        prod;
  logic signed [FRAME_W-1:0] res_frame;
  status_t                   res_status;

  logic signed [FRAME_W-1:0] e_cl;
  logic [ENTRY_W-1:0]        rd_data;
  logic [IDX_W-1:0]          raddr;
  logic [INDEX_W-1:0]        diff;
  logic [INDEX_W:0]          span;
  logic signed [FRAME_W:0]   gap;
  logic signed [TMP_W+1:0]   tmp_s, gap_w;
  logic signed [FRAME_W+1:0] isum;
  logic [INDEX_W-1:0]        dividend;
  logic [INDEX_W-1:0]        quo;
  logic [STEP_W-1:0]         rem;
  logic                      div_done;

  // table storage: step, end, start from the top down
  assign e_cl   = (a_e < a_s) ? a_s : a_e;
  assign r_plus = r + CNT_W'(1);
  assign raddr  = cmd.rd_next ? r_plus[IDX_W-1:0] : r[IDX_W-1:0];

  fril_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_RANGES)) u_ram (
    .clk   (clk),
    .we    (cmd.do_append),
    .waddr (count[IDX_W-1:0]),
    .wdata ({a_st, e_cl, a_s}),
    .re    (cmd.ram_rd),
    .raddr (raddr),
    .rdata (rd_data)
  );

  // per-range arithmetic
  assign diff  = cur_e - cur_s;
  assign span  = {1'b0, diff} + (INDEX_W + 1)'(1);
  assign gap   = (FRAME_W + 1)'(ns) - (FRAME_W + 1)'(cur_s);
  assign tmp_s = $signed({2'b00, tmp});
  assign gap_w = (TMP_W + 2)'(gap);
  assign isum  = $signed({2'b00, tmp[INDEX_W-1:0]}) + (FRAME_W + 2)'(lo);

  assign dividend = (cmd.div_sel == DIV_TMP) ? tmp[INDEX_W-1:0] : diff;

  fril_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (dividend),
    .divisor   (cur_st),
    .quotient  (quo),
    .remainder (rem),
    .done      (div_done)
  );

  // status to the controller
  assign st.act         = act;
  assign st.implied     = imp;
  assign st.snap        = snp;
  assign st.cnt_zero    = (count == '0);
  assign st.append_bad  = (a_st == '0) || (count >= CNT_W'(MAX_RANGES));
  assign st.last        = (r_plus == count);
  assign st.tmp_lt_cnt  = tmp < TMP_W'(cnt);
  assign st.tmp_lt_span = tmp < TMP_W'(span);
  assign st.gap_hit     = tmp_s < gap_w;
  assign st.div_done    = div_done;
  assign st.out_free    = !out_valid || out_ready;

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.do_clear) count <= '0;
      else if (cmd.do_append) count <= count + CNT_W'(1);
      if (cmd.out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // walk and payload registers
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      act  <= action_t'(in_action);
      a_s  <= in_start;
      a_e  <= in_end;
      a_st <= in_step;
      imp  <= in_implied;
      snp  <= in_snap;
      tmp  <= TMP_W'(in_index);
      r    <= '0;
    end else begin
      if (cmd.r_inc) r <= r_plus;
      if (cmd.tmp_sub_cnt) tmp <= tmp - TMP_W'(cnt);
      else if (cmd.tmp_sub_gap) tmp <= TMP_W'(tmp_s - gap_w);
    end
    if (cmd.latch_cur) begin
      cur_s  <= rd_data[FRAME_W-1:0];
      cur_e  <= rd_data[2*FRAME_W-1:FRAME_W];
      cur_st <= rd_data[ENTRY_W-1:2*FRAME_W];
    end
    if (cmd.latch_next) ns <= rd_data[FRAME_W-1:0];
    if (cmd.lo_load && (r == '0 || cur_s < lo)) lo <= cur_s;
    if (cmd.cnt_load) cnt <= {1'b0, quo} + (INDEX_W + 1)'(1);
    if (cmd.prod_load) prod <= FRAME_W'(tmp[INDEX_W-1:0] * {1'b0, cur_st});
    if (cmd.out_load) begin
      out_frame  <= res_frame;
      out_status <= res_status;
      out_held   <= HELD_W'(count);
    end
  end

  // result selection
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      case (cmd.res_sel)
        RES_LISTED: begin
          res_frame  <= cur_s + $signed(prod);
          res_status <= ST_OK;
        end
        RES_IMPLIED: begin
          if (isum > (FRAME_W + 2)'(32'sh7fffffff)) begin
            res_frame  <= '0;
            res_status <= ST_RANGE;
          end else begin
            res_frame  <= FRAME_W'(isum);
            res_status <= ST_OK;
          end
        end
        RES_SNAP: begin
          res_frame  <= cur_s + $signed(tmp[INDEX_W-1:0] - INDEX_W'(rem));
          res_status <= ST_OK;
        end
        RES_STEPEND: begin
          res_frame  <= cur_e - $signed(INDEX_W'(rem));
          res_status <= ST_OK;
        end
        RES_EMPTY: begin
          res_frame  <= '0;
          res_status <= ST_EMPTY;
        end
        RES_RANGE: begin
          res_frame  <= '0;
          res_status <= ST_RANGE;
        end
        RES_REJECT: begin
          res_frame  <= '0;
          res_status <= ST_REJECT;
        end
        default: begin
          res_frame  <= '0;
          res_status <= ST_OK;
        end
      endcase
    end
  end
endmodule

### sv/frame_range_index_lookup.sv
// Frame range table: appends or clears stepped ranges and maps an index to a
// frame number. One item is taken at a time; a result waits in an output
// register, so the next item is accepted while it is still unread. A query
// walks the stored ranges one by one through a table with one read port and
// one shared divider: implied mode reads every range, listed mode runs one
// division per range visited, and gap-spanning mode reads each range and the
// next start per gap crossed, ending with one division when a frame is found.
module frame_range_index_lookup
  import fril_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // range_start, range_end, range_step, query_index, zero pad
  input  logic [127:0] s_tdata,
  // action, implied_mode, snap_valid
  input  logic [3:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // frame_number, status, ranges_held, zero pad
  output logic [39:0]  m_tdata
);
  cmd_t                      cmd;
  stat_t                     st;
  logic signed [FRAME_W-1:0] out_frame;
  logic [STAT_W-1:0]         out_status;
  logic [HELD_W-1:0]         out_held;

  // sequencer
  fril_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  // datapath
  fril_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .st         (st),
    .in_action  (s_tuser[1:0]),
    .in_start   (s_tdata[31:0]),
    .in_end     (s_tdata[63:32]),
    .in_step    (s_tdata[94:64]),
    .in_index   (s_tdata[126:95]),
    .in_implied (s_tuser[2]),
    .in_snap    (s_tuser[3]),
    .out_ready  (m_tready),
    .out_valid  (m_tvalid),
    .out_frame  (out_frame),
    .out_status (out_status),
    .out_held   (out_held)
  );

  assign m_tdata = {1'b0, out_held, out_status, out_frame};

  // checks
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("new beat taken while an item is in work");

  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_held <= HELD_W'(MAX_RANGES)))
    else $error("range count beyond table depth");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_status != ST_OK) |-> (out_frame == '0))
    else $error("nonzero frame with error status");
endmodule

### sim/tb.sv
// self-checking testbench for the frame range index lookup block
`timescale 1ns / 100ps

module tb;
  import fril_pkg::*;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [127:0] s_tdata = '0;
  logic [3:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [39:0]  m_tdata;

  typedef struct packed {
    action_t     act;
    logic [31:0] rstart;
    logic [31:0] rend;
    logic [30:0] rstep;
    logic [31:0] qidx;
    logic        implied;
    logic        snap;
  } cmd_item_t;

  typedef struct packed {
    logic [31:0] frame;
    status_t     status;
    logic [4:0]  held;
  } lookup_res_t;

  cmd_item_t   pending_q[$];
  lookup_res_t expected_q[$];

  // predictor copy of the range table
  longint tbl_start[MAX_RANGES];
  longint tbl_end[MAX_RANGES];
  longint tbl_step[MAX_RANGES];
  int     tbl_count = 0;

  int  errors = 0;
  int  n_results = 0;
  int  n_queries = 0;
  int  cycle = 0;
  bit  stim_done = 0;
  bit  hold_off = 0;
  bit  in_taken = 0;

  frame_range_index_lookup dut (.*);

  always #1 clk = ~clk;

  // walk the table the way the block does and return status and frame
  function automatic lookup_res_t predict_lookup(cmd_item_t it);
    lookup_res_t res;
    longint tmp, lo, s, e, st, span, cnt, ns, frame;
    status_t stat;
    int r;
    bit found;
    frame = 0;
    stat = ST_OK;
    case (it.act)
      ACT_CLEAR: tbl_count = 0;
      ACT_APPEND: begin
        s  = longint'($signed(it.rstart));
        e  = longint'($signed(it.rend));
        st = longint'(it.rstep);
        if (st == 0 || tbl_count >= MAX_RANGES) stat = ST_REJECT;
        else begin
          if (e < s) e = s;
          tbl_start[tbl_count] = s;
          tbl_end[tbl_count] = e;
          tbl_step[tbl_count] = st;
          tbl_count++;
        end
      end
      ACT_QUERY: begin
        tmp = longint'(it.qidx);
        found = 0;
        if (tbl_count == 0) stat = ST_EMPTY;
        else if (it.implied && !it.snap) begin
          lo = tbl_start[0];
          for (r = 1; r < tbl_count; r++) if (tbl_start[r] < lo) lo = tbl_start[r];
          if (tmp + lo > 64'sd2147483647) stat = ST_RANGE;
          else frame = tmp + lo;
        end else begin
          for (r = 0; r < tbl_count && !found; r++) begin
            s = tbl_start[r];
            e = tbl_end[r];
            st = tbl_step[r];
            if (it.implied) begin
              span = e - s + 1;
              if (tmp < span) begin
                frame = (tmp / st) * st + s;
                found = 1;
              end else if (r + 1 < tbl_count) begin
                ns = tbl_start[r + 1];
                if (tmp + s < ns) begin
                  frame = e - ((e - s) % st);
                  found = 1;
                end else tmp -= ns - s;
              end else tmp -= span;
            end else begin
              cnt = (e - s) / st + 1;
              if (tmp < cnt) begin
                frame = s + tmp * st;
                found = 1;
              end else tmp -= cnt;
            end
          end
          if (!found) stat = ST_RANGE;
        end
        if (stat != ST_OK) frame = 0;
      end
      default: ;
    endcase
    res.frame = frame[31:0];
    res.status = stat;
    res.held = tbl_count[4:0];
    return res;
  endfunction

  function automatic cmd_item_t mk(action_t a, int s, int e, int st, int q, bit im, bit sn);
    cmd_item_t it;
    it.act = a;
    it.rstart = s;
    it.rend = e;
    it.rstep = st[30:0];
    it.qidx = q;
    it.implied = im;
    it.snap = sn;
    return it;
  endfunction

  // append one item to the stimulus list
  function automatic void queue_item(cmd_item_t it);
    pending_q.insert(pending_q.size(), it);
  endfunction

  function automatic cmd_item_t rand_query();
    cmd_item_t it;
    it = mk(ACT_QUERY, $urandom, $urandom, $urandom, 0, $urandom_range(0, 1),
            $urandom_range(0, 1));
    case ($urandom_range(0, 3))
      0: it.qidx = $urandom;
      1: it.qidx = $urandom_range(0, 20);
      default: it.qidx = $urandom_range(0, 600);
    endcase
    return it;
  endfunction

  // random ascending range set followed by queries
  task automatic add_frame_set();
    int n, base, len, gap;
    n = $urandom_range(0, 4) == 0 ? $urandom_range(14, 18) : $urandom_range(1, 5);
    base = $urandom_range(0, 3) == 0 ? int'($urandom) : $urandom_range(0, 2000) - 1000;
    queue_item(mk(ACT_CLEAR, $urandom, $urandom, $urandom, $urandom,
                  $urandom_range(0, 1), $urandom_range(0, 1)));
    for (int i = 0; i < n; i++) begin
      len = $urandom_range(0, 60);
      gap = $urandom_range(0, 40);
      queue_item(mk(ACT_APPEND, base, base + len - ($urandom_range(0, 9) == 0 ? 70 : 0),
                    $urandom_range(0, 15) == 0 ? 0 :
                    ($urandom_range(0, 9) == 0 ? int'($urandom) : $urandom_range(1, 9)),
                    $urandom, $urandom_range(0, 1), $urandom_range(0, 1)));
      base = base + len + gap;
    end
    for (int i = 0; i < $urandom_range(3, 10); i++) queue_item(rand_query());
  endtask

  // input handshake seen at the rising edge
  always @(posedge clk) begin
    in_taken <= !rst && s_tvalid && s_tready;
  end

  // driver: offer beats at the falling edge, with random gaps
  int gap_left = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (!s_tvalid || in_taken) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          s_tvalid <= 1'b0;
        end else if (pending_q.size() > 0) begin
          s_tvalid <= 1'b1;
          s_tdata <= {1'b0, pending_q[0].qidx, pending_q[0].rstep,
                      pending_q[0].rend, pending_q[0].rstart};
          s_tuser <= {pending_q[0].snap, pending_q[0].implied, pending_q[0].act};
          expected_q.insert(expected_q.size(), predict_lookup(pending_q[0]));
          pending_q.delete(0);
          gap_left <= $urandom_range(0, 9) == 0 ? $urandom_range(5, 60) :
                      ($urandom_range(0, 1) ? 0 : $urandom_range(0, 3));
        end else begin
          s_tvalid <= 1'b0;
          stim_done <= 1'b1;
        end
      end
    end
  end

  // receiver backpressure at the falling edge
  always @(negedge clk) begin
    if (rst || hold_off) m_tready <= 1'b0;
    else if ($urandom_range(0, 19) == 0) m_tready <= 1'b0;
    else m_tready <= $urandom_range(0, 3) != 0;
  end

  // monitor: compare each result beat against the oldest prediction
  always @(posedge clk) begin
    lookup_res_t got, exp_r;
    cycle <= cycle + 1;
    if (!rst && m_tvalid && m_tready) begin
      got.frame = m_tdata[31:0];
      got.status = status_t'(m_tdata[33:32]);
      got.held = m_tdata[38:34];
      n_results <= n_results + 1;
      if (expected_q.size() == 0) begin
        $error("result beat with nothing expected: %h", m_tdata);
        errors = errors + 1;
      end else begin
        exp_r = expected_q[0];
        expected_q.delete(0);
        if (got.frame !== exp_r.frame) begin
          $error("frame_number expected %0d actual %0d", $signed(exp_r.frame),
                 $signed(got.frame));
          errors = errors + 1;
        end
        if (got.status !== exp_r.status) begin
          $error("status expected %0d actual %0d", exp_r.status, got.status);
          errors = errors + 1;
        end
        if (got.held !== exp_r.held) begin
          $error("ranges_held expected %0d actual %0d", exp_r.held, got.held);
          errors = errors + 1;
        end
      end
    end
  end

  // long receiver stall while the sender keeps offering
  initial begin
    wait (!rst);
    repeat (3000) @(posedge clk);
    @(negedge clk);
    hold_off = 1'b1;
    repeat (2000) @(negedge clk);
    hold_off = 1'b0;
  end

  // run limit
  initial begin
    wait (cycle >= 4000000);
    $display("frame_range_index_lookup regression: fail");
    $finish;
  end

  initial begin
    // directed: empty table, field extremes, each mode and corner case
    queue_item(mk(ACT_QUERY, 0, 0, 0, 0, 0, 0));
    queue_item(mk(ACT_QUERY, -1, -1, -1, -1, 1, 1));
    queue_item(mk(ACT_NONE, -1, -1, -1, -1, 1, 1));
    queue_item(mk(ACT_APPEND, 10, 20, 0, 0, 0, 0));
    queue_item(mk(ACT_APPEND, 10, 20, 3, 0, 0, 0));
    queue_item(mk(ACT_APPEND, 30, 25, 1, 0, 0, 0));
    queue_item(mk(ACT_APPEND, 40, 50, 4, 0, 0, 0));
    queue_item(mk(ACT_QUERY, 0, 0, 0, 5, 0, 0));
    queue_item(mk(ACT_QUERY, 0, 0, 0, 7, 0, 0));
    queue_item(mk(ACT_QUERY, 0, 0, 0, 15, 1, 1));
    queue_item(mk(ACT_QUERY, 0, 0, 0, 100, 1, 1));
    queue_item(mk(ACT_QUERY, 0, 0, 0, 12, 1, 0));
    queue_item(mk(ACT_QUERY, 0, 0, 0, -1, 1, 0));
    queue_item(mk(ACT_CLEAR, 0, 0, 0, 0, 0, 0));
    queue_item(mk(ACT_APPEND, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 0, 0, 0));
    queue_item(mk(ACT_APPEND, 5, -5, 1, 0, 0, 0));
    queue_item(mk(ACT_QUERY, 0, 0, 0, 1, 0, 0));
    queue_item(mk(ACT_QUERY, 0, 0, 0, 2, 0, 0));
    queue_item(mk(ACT_QUERY, 0, 0, 0, 32'hffff_ffff, 1, 1));
    queue_item(mk(ACT_QUERY, 0, 0, 0, 32'hffff_ffff, 1, 0));
    for (int i = 0; i < 17; i++) queue_item(mk(ACT_APPEND, i * 10, i * 10 + 5, 2, 0, 0, 0));
    queue_item(mk(ACT_QUERY, 0, 0, 0, 40, 0, 0));
    queue_item(mk(ACT_QUERY, 0, 0, 0, 155, 1, 1));
    // random: mostly sorted range sets with queries, some noise
    while (pending_q.size() < 1850) begin
      if ($urandom_range(0, 4) == 0)
        queue_item(mk(action_t'($urandom_range(0, 3)), $urandom, $urandom, $urandom,
                      $urandom, $urandom_range(0, 1), $urandom_range(0, 1)));
      else add_frame_set();
    end
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    wait (stim_done && expected_q.size() == 0);
    repeat (700) @(posedge clk);
    $display("covered %0d result beats over clear, append and three query modes,",
             n_results);
    $display("with full tables, bad steps, gaps and a long output stall");
    if (errors == 0 && expected_q.size() == 0) begin
      $display("frame_range_index_lookup regression: pass");
    end else begin
      $display("frame_range_index_lookup regression: fail");
    end
    $finish;
  end

endmodule
